// ===== hw/rtl/glos_pkg.sv =====
// shared constants, types and helpers for the grid line-of-sight block
package glos_pkg;

    localparam int MAP_WIDTH  = 64;
    localparam int MAP_HEIGHT = 64;
    localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W     = $clog2(MAP_DEPTH);
    localparam int COORD_W    = 6;
    localparam int ERR_W      = COORD_W + 2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic signed [ERR_W-1:0] err_t;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SETUP  = 6'b000100,
        ST_WALK   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    function automatic addr_t tile_addr(input coord_t row, input coord_t col);
        tile_addr = ADDR_W'(32'(row) * MAP_WIDTH + 32'(col));
    endfunction

    function automatic logic tile_inside(input coord_t row, input coord_t col);
        tile_inside = (32'(col) < MAP_WIDTH) && (32'(row) < MAP_HEIGHT);
    endfunction

endpackage

// ===== hw/rtl/glos_if.sv =====
// request and response channel interfaces
interface glos_req_if;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    glos_pkg::coord_t       tile_x;
    glos_pkg::coord_t       tile_y;
    logic                   tile_solid;
    glos_pkg::coord_t       origin_x;
    glos_pkg::coord_t       origin_y;
    glos_pkg::coord_t       target_x;
    glos_pkg::coord_t       target_y;

    modport source (
        output valid, cmd, tile_x, tile_y, tile_solid, origin_x, origin_y, target_x, target_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, tile_x, tile_y, tile_solid, origin_x, origin_y, target_x, target_y,
        output ready
    );
endinterface

interface glos_rsp_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );
    modport sink (
        input  valid, visible,
        output ready
    );
endinterface

// ===== hw/rtl/glos_ram.sv =====
// generic simple dual-port ram with registered read
module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/grid_line_of_sight.sv =====
// top level: tile collision map and bresenham line-of-sight walker
//
//   channel | dir | payload                                          | transfer
//   req     | in  | cmd, tile_x/y, tile_solid, origin_x/y, target_x/y | valid & ready
//   rsp     | out | visible (one per query, none per write)           | valid & ready
//
// after reset a clearing pass zeroes all MAP_DEPTH map words, req not ready
// a write transfer updates the map in its own cycle and the block stays idle
// a query steps through setup, then walk at one major-axis cell per cycle, then drain and finish;
// the walk is bounded by the single map read port walked one cell per cycle
// a held response stalls only the finish step; req is ready again once it is loaded
module grid_line_of_sight (
    input  logic        clk,
    input  logic        rst_n,
    glos_req_if.sink    req,
    glos_rsp_if.source  rsp
);
    import glos_pkg::*;

    state_t state_reg, state_next;
    addr_t  clr_cnt_reg;

    coord_t ox_reg, oy_reg, tx_reg, ty_reg;
    coord_t major_reg, end_reg, minor_reg, run_reg, rise_reg;
    err_t   err_reg;
    logic   steep_reg, up_reg;
    logic   blocked_reg;
    logic   chk_valid_reg, chk_out_reg;
    logic   out_valid_reg, visible_reg;

    logic   req_xfer, rsp_xfer;
    logic   ram_we, ram_wdata;
    addr_t  ram_waddr, ram_raddr;
    logic [0:0] ram_rdata;

    // setup values
    coord_t adx, ady, ax0, ay0, bx0, by0, s_ax, s_ay, s_bx, s_by, s_run, s_rise;
    logic   s_steep, s_swap;

    // walk values
    coord_t cx, cy;
    err_t   err_dec, err_inc;
    logic   cell_skip, walk_last;

    assign req_xfer = req.valid && req.ready;
    assign rsp_xfer = rsp.valid && rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.visible = visible_reg;

    always_comb
    begin
        adx     = (tx_reg >= ox_reg) ? tx_reg - ox_reg : ox_reg - tx_reg;
        ady     = (ty_reg >= oy_reg) ? ty_reg - oy_reg : oy_reg - ty_reg;
        s_steep = ady > adx;
        ax0     = s_steep ? oy_reg : ox_reg;
        ay0     = s_steep ? ox_reg : oy_reg;
        bx0     = s_steep ? ty_reg : tx_reg;
        by0     = s_steep ? tx_reg : ty_reg;
        s_swap  = ax0 > bx0;
        s_ax    = s_swap ? bx0 : ax0;
        s_ay    = s_swap ? by0 : ay0;
        s_bx    = s_swap ? ax0 : bx0;
        s_by    = s_swap ? ay0 : by0;
        s_run   = s_bx - s_ax;
        s_rise  = (s_by >= s_ay) ? s_by - s_ay : s_ay - s_by;
    end

    always_comb
    begin
        cx        = steep_reg ? minor_reg : major_reg;
        cy        = steep_reg ? major_reg : minor_reg;
        cell_skip = (cx == ox_reg) && (cy == oy_reg);
        walk_last = (major_reg == end_reg);
        err_dec   = err_reg - ERR_W'(rise_reg);
        err_inc   = err_dec + ERR_W'(run_reg);
    end

    // map write port: clearing pass or tile write
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = req_xfer && (req.cmd == CMD_WRITE) && tile_inside(req.tile_y, req.tile_x);
            ram_waddr = tile_addr(req.tile_y, req.tile_x);
            ram_wdata = req.tile_solid;
        end
    end

    assign ram_raddr = tile_addr(cy, cx);

    glos_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(MAP_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_xfer && (req.cmd == CMD_QUERY))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= (state_reg == ST_WALK) && !cell_skip;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if ((state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            ox_reg <= req.origin_x;
            oy_reg <= req.origin_y;
            tx_reg <= req.target_x;
            ty_reg <= req.target_y;
        end

        chk_out_reg <= !tile_inside(cy, cx);

        if (chk_valid_reg && (chk_out_reg || ram_rdata[0]))
        begin
            blocked_reg <= 1'b1;
        end

        unique case (state_reg)
            ST_SETUP:
            begin
                steep_reg   <= s_steep;
                major_reg   <= s_ax;
                end_reg     <= s_bx;
                minor_reg   <= s_ay;
                run_reg     <= s_run;
                rise_reg    <= s_rise;
                up_reg      <= s_ay < s_by;
                err_reg     <= ERR_W'(s_run >> 1);
                blocked_reg <= 1'b0;
            end
            ST_WALK:
            begin
                major_reg <= major_reg + 1'b1;
                if (err_dec < 0)
                begin
                    minor_reg <= up_reg ? minor_reg + 1'b1 : minor_reg - 1'b1;
                    err_reg   <= err_inc;
                end
                else
                begin
                    err_reg <= err_dec;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    visible_reg <= !blocked_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_rsp_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("response valid during map clearing");

    a_query_enters_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && (req.cmd == CMD_QUERY)) |=> (state_reg == ST_SETUP))
        else $error("accepted query did not start setup");

    a_err_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> ((err_reg >= 0) && (err_reg <= ERR_W'(run_reg))))
        else $error("bresenham error term out of range");

    a_no_map_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) || (state_reg == ST_DRAIN)) |-> !ram_we)
        else $error("map written during a query walk");
`endif

endmodule

// ===== tb/glos_sight_checker.sv =====
// checker for the grid line-of-sight block: map shadow, bresenham predictor, response compare
module glos_sight_checker (
    input  logic  clk,
    input  logic  rst_n,
    glos_req_if   req,
    glos_rsp_if   rsp,
    output int    failures,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import glos_pkg::*;

    logic blocked [MAP_DEPTH];
    logic visible_q [$];

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    // walks the line between origin and target; off-map cells count as walls
    function automatic logic sight_clear(input int ox, input int oy, input int tx, input int ty);
        int  ax, ay, bx, by, hold, run, rise, slack, minor, stride, cx, cy, span_x, span_y;
        logic steep;
        ax = ox;
        ay = oy;
        bx = tx;
        by = ty;
        span_x = (bx > ax) ? bx - ax : ax - bx;
        span_y = (by > ay) ? by - ay : ay - by;
        steep = span_y > span_x;
        if (steep)
        begin
            hold = ax; ax = ay; ay = hold;
            hold = bx; bx = by; by = hold;
        end
        if (ax > bx)
        begin
            hold = ax; ax = bx; bx = hold;
            hold = ay; ay = by; by = hold;
        end
        run    = bx - ax;
        rise   = (by > ay) ? by - ay : ay - by;
        slack  = run / 2;
        minor  = ay;
        stride = (ay < by) ? 1 : -1;
        for (int major = ax; major <= bx; major++)
        begin
            cx = steep ? minor : major;
            cy = steep ? major : minor;
            if (!(cx == ox && cy == oy))
            begin
                if (cx < 0 || cy < 0 || cx >= MAP_WIDTH || cy >= MAP_HEIGHT)
                    return 1'b0;
                if (blocked[cy * MAP_WIDTH + cx])
                    return 1'b0;
            end
            slack -= rise;
            if (slack < 0)
            begin
                minor += stride;
                slack += run;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        if (!rst_n)
        begin
            foreach (blocked[i])
                blocked[i] = 1'b0;
            visible_q.delete();
        end
        else
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                if (req.cmd == CMD_WRITE)
                begin
                    if (int'(req.tile_x) < MAP_WIDTH && int'(req.tile_y) < MAP_HEIGHT)
                        blocked[int'(req.tile_y) * MAP_WIDTH + int'(req.tile_x)] = req.tile_solid;
                end
                else
                    visible_q.push_back(sight_clear(int'(req.origin_x), int'(req.origin_y),
                                                    int'(req.target_x), int'(req.target_y)));
            end
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (visible_q.size() == 0)
                begin
                    $display("%0t: response with no query outstanding, expected none, got visible=%b",
                             $time, rsp.visible);
                    failures++;
                end
                else
                begin
                    want = visible_q.pop_front();
                    if (rsp.visible !== want)
                    begin
                        $display("%0t: visible mismatch, expected %b, got %b",
                                 $time, want, rsp.visible);
                        failures++;
                    end
                end
            end
        end
        pending = visible_q.size();
    end

endmodule

// ===== tb/grid_line_of_sight_tb.sv =====
// top testbench for the grid line-of-sight block: clock, reset, stimulus and verdict
module grid_line_of_sight_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import glos_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_left;
    int   win_x;
    int   win_y;

    glos_req_if req_ch ();
    glos_rsp_if rsp_ch ();

    grid_line_of_sight DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    glos_sight_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response side: long hold-off when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready = 1'b0;
        end
        else
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // one request transfer; valid is left high so back-to-back items need no dip
    task automatic offer(input logic cmd, input coord_t tx, input coord_t ty, input logic solid,
                         input coord_t ox, input coord_t oy, input coord_t gx, input coord_t gy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.cmd        = cmd;
        req_ch.tile_x     = tx;
        req_ch.tile_y     = ty;
        req_ch.tile_solid = solid;
        req_ch.origin_x   = ox;
        req_ch.origin_y   = oy;
        req_ch.target_x   = gx;
        req_ch.target_y   = gy;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // unused fields carry random junk
    task automatic put_tile(input int x, input int y, input logic solid);
        offer(CMD_WRITE, coord_t'(x), coord_t'(y), solid,
              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic ask_sight(input int ox, input int oy, input int gx, input int gy);
        offer(CMD_QUERY, coord_t'($urandom), coord_t'($urandom), 1'($urandom),
              coord_t'(ox), coord_t'(oy), coord_t'(gx), coord_t'(gy));
    endtask

    task automatic settle();
        req_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (80) @(negedge clk);
    endtask

    // mostly local traffic in a small window so lines hit the written tiles
    task automatic random_traffic(input int count);
        int   ox, oy, gx, gy;
        logic near;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 20)
            begin
                win_x = $urandom_range(56);
                win_y = $urandom_range(56);
            end
            near = ($urandom_range(99) < 70);
            if ($urandom_range(99) < 40)
            begin
                if (near)
                    put_tile(win_x + $urandom_range(7), win_y + $urandom_range(7),
                             $urandom_range(99) < 55);
                else
                    put_tile($urandom_range(63), $urandom_range(63), $urandom_range(99) < 55);
            end
            else
            begin
                if (near)
                begin
                    ox = win_x + $urandom_range(7);
                    oy = win_y + $urandom_range(7);
                    gx = win_x + $urandom_range(7);
                    gy = win_y + $urandom_range(7);
                end
                else
                begin
                    ox = $urandom_range(63);
                    oy = $urandom_range(63);
                    gx = $urandom_range(63);
                    gy = $urandom_range(63);
                end
                if ($urandom_range(99) < 5)
                begin
                    gx = ox;
                    gy = oy;
                end
                ask_sight(ox, oy, gx, gy);
            end
        end
    endtask

    initial
    begin
        cycles            = 0;
        hold_left         = 0;
        win_x             = 0;
        win_y             = 0;
        send_idle_pct     = 10;
        recv_idle_pct     = 46;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_WRITE;
        req_ch.tile_x     = '0;
        req_ch.tile_y     = '0;
        req_ch.tile_solid = 1'b0;
        req_ch.origin_x   = '0;
        req_ch.origin_y   = '0;
        req_ch.target_x   = '0;
        req_ch.target_y   = '0;
        rsp_ch.ready      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: corners, steep and shallow lines, walls on the endpoints
        ask_sight(0, 0, 0, 0);
        ask_sight(0, 0, 63, 63);
        ask_sight(63, 0, 0, 63);
        put_tile(63, 63, 1'b1);
        put_tile(0, 0, 1'b1);
        ask_sight(0, 0, 63, 63);
        ask_sight(63, 63, 0, 0);
        ask_sight(0, 0, 0, 0);
        ask_sight(0, 0, 1, 0);
        put_tile(10, 30, 1'b1);
        ask_sight(10, 0, 10, 63);
        ask_sight(12, 63, 8, 0);
        ask_sight(63, 0, 0, 5);
        ask_sight(0, 5, 63, 0);
        put_tile(31, 2, 1'b1);
        ask_sight(0, 5, 63, 0);
        ask_sight(63, 0, 0, 5);
        put_tile(31, 2, 1'b0);
        put_tile(0, 0, 1'b0);
        put_tile(63, 63, 1'b0);
        put_tile(10, 30, 1'b0);
        ask_sight(0, 0, 63, 63);
        ask_sight(10, 0, 10, 63);
        ask_sight(5, 7, 6, 20);
        settle();

        random_traffic(190);
        settle();

        send_idle_pct = 46;
        recv_idle_pct = 10;
        @(negedge clk);
        hold_left = 400;
        random_traffic(200);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(200);
        settle();

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/glos_pkg.sv
hw/rtl/glos_if.sv
hw/rtl/glos_ram.sv
hw/rtl/grid_line_of_sight.sv
tb/glos_sight_checker.sv
tb/grid_line_of_sight_tb.sv
